[sv/cicmd_pkg.sv]
// shared types, constants and helpers for the cloud-in-cell mass deposit block
// no dependencies; used by every module of the block
`default_nettype none
package cicmd_pkg;

  localparam int MESH_SIDE = 32;
  localparam int POS_BITS  = 24;
  localparam int ACC_W     = 48;
  localparam int FLD_W     = 24;
  localparam int IDX_W     = 15;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  // item kinds
  localparam logic KIND_DEPOSIT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [FLD_W-1:0] pos_x;
    logic [FLD_W-1:0] pos_y;
    logic [FLD_W-1:0] pos_z;
    logic [FLD_W-1:0] mass;
    logic             active;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] cell_mass;
    logic [ACC_W-1:0] run_total;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       clr;
    logic       split;
    logic       mul1;
    logic       mul2;
    logic       mul3;
    logic       wr;
    logic       rda;
    logic       rdb;
    logic       fin;
    logic [2:0] corner;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/cicmd_datapath.sv]
// datapath: offsets, axis split, corner weights, mesh memory and result register
// depends on cicmd_pkg
`default_nettype none
module cicmd_datapath #(
  parameter int MeshSide = cicmd_pkg::MESH_SIDE,
  parameter int PosBits  = cicmd_pkg::POS_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cicmd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cicmd_pkg::FLD_W-1:0]    cfg_data_i,
  input  wire cicmd_pkg::in_item_t            in_data_i,
  input  wire cicmd_pkg::cmd_t                cmd_i,
  output cicmd_pkg::sts_t                     sts_o,
  output cicmd_pkg::out_item_t                out_data_o
);

  localparam int Cells = MeshSide * MeshSide * MeshSide;
  localparam int AW    = $clog2(Cells);
  localparam int BW    = $clog2(MeshSide);
  localparam int PW    = PosBits + BW;
  localparam int AccW  = cicmd_pkg::ACC_W;
  localparam int FldW  = cicmd_pkg::FLD_W;

  logic [FldW-1:0]    off_q [3];
  cicmd_pkg::in_item_t item_q;
  logic [BW-1:0]      base_q [3];
  logic [15:0]        f16_q [3];
  logic [33:0]        wxy_q;
  logic [16:0]        w_q;
  logic [AW-1:0]      lin_q;
  logic [FldW-1:0]    contrib_q;
  logic [AccW-1:0]    rd_q;
  logic [AccW-1:0]    cell_q;
  logic [AccW-1:0]    total_q;
  logic [AW-1:0]      clr_q;
  cicmd_pkg::out_item_t out_q;
  logic [AccW-1:0]    mesh_mem [Cells];

  logic [FldW-1:0]    pos3 [3];
  logic [PosBits-1:0] wrap [3];
  logic [PW-1:0]      prod [3];
  logic [47:0]        fx [3];
  logic [16:0]        wsel [3];
  logic [BW:0]        cs [3];
  logic [31:0]        lin32;
  logic [50:0]        wprod;
  logic [40:0]        mprod;
  logic [31:0]        idx32;
  logic               in_range;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [AccW-1:0]    mem_wdata;

  assign pos3[0] = item_q.pos_x;
  assign pos3[1] = item_q.pos_y;
  assign pos3[2] = item_q.pos_z;

  // per-axis wrap, base cell and 16-bit fraction; corner weight and cell
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      wrap[d] = PosBits'(32'(pos3[d]) - 32'(off_q[d]));
      prod[d] = PW'(wrap[d]) * PW'(MeshSide);
      fx[d]   = 48'(prod[d][PosBits-1:0]) << 16;
      wsel[d] = cmd_i.corner[d] ? {1'b0, f16_q[d]} : 17'h10000 - {1'b0, f16_q[d]};
      cs[d]   = {1'b0, base_q[d]} + (BW+1)'(cmd_i.corner[d]);
      if (cs[d] >= (BW+1)'(MeshSide)) begin
        cs[d] = cs[d] - (BW+1)'(MeshSide);
      end
    end
  end

  assign lin32 = (32'(cs[0]) * 32'(MeshSide) + 32'(cs[1])) * 32'(MeshSide) + 32'(cs[2]);
  assign wprod = 51'(wxy_q) * 51'(wsel[2]);
  assign mprod = 41'(item_q.mass) * 41'(w_q) + 41'(32768);
  assign idx32 = 32'(item_q.cell_index);
  assign in_range = idx32 < 32'(Cells);

  // single memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = lin_q;
    mem_wdata = '0;
    priority if (cmd_i.clr) begin
      mem_we   = 1'b1;
      mem_addr = clr_q;
    end else if (cmd_i.mul2) begin
      mem_re = 1'b1;
    end else if (cmd_i.wr) begin
      mem_we    = (w_q != '0);
      mem_wdata = cicmd_pkg::sat_add(rd_q, AccW'(contrib_q));
    end else if (cmd_i.rda) begin
      mem_re   = in_range;
      mem_addr = idx32[AW-1:0];
    end else if (cmd_i.rdb) begin
      mem_we   = in_range;
      mem_addr = idx32[AW-1:0];
    end else begin
      mem_addr = lin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mesh_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mesh_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
      total_q  <= '0;
      clr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cicmd_pkg::REG_OFFSET_X: off_q[0] <= cfg_data_i;
          cicmd_pkg::REG_OFFSET_Y: off_q[1] <= cfg_data_i;
          cicmd_pkg::REG_OFFSET_Z: off_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.split) begin
        total_q <= cicmd_pkg::sat_add(total_q, AccW'(item_q.mass));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      cell_q <= '0;
    end
    if (cmd_i.split) begin
      for (int d = 0; d < 3; d++) begin
        base_q[d] <= prod[d][PW-1:PosBits];
        f16_q[d]  <= fx[d][PosBits+15:PosBits];
      end
    end
    if (cmd_i.mul1) begin
      wxy_q <= 34'(wsel[0]) * 34'(wsel[1]);
      lin_q <= lin32[AW-1:0];
    end
    if (cmd_i.mul2) begin
      w_q <= wprod[48:32];
    end
    if (cmd_i.mul3) begin
      contrib_q <= mprod[39:16];
    end
    if (cmd_i.rdb) begin
      cell_q <= in_range ? rd_q : '0;
    end
    if (cmd_i.fin) begin
      out_q.cell_mass <= cell_q;
      out_q.run_total <= total_q;
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(Cells - 1));
  assign out_data_o     = out_q;

endmodule
`default_nettype wire

[sv/cicmd_ctrl.sv]
// controller: clearing sweep, item sequencing over eight corners, output handshake
// depends on cicmd_pkg
`default_nettype none
module cicmd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            in_kind_i,
  input  wire logic            in_active_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire cicmd_pkg::sts_t sts_i,
  output cicmd_pkg::cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    ST_CLR   = 10'b00_0000_0001,
    ST_IDLE  = 10'b00_0000_0010,
    ST_SPLIT = 10'b00_0000_0100,
    ST_MUL1  = 10'b00_0000_1000,
    ST_MUL2  = 10'b00_0001_0000,
    ST_MUL3  = 10'b00_0010_0000,
    ST_WR    = 10'b00_0100_0000,
    ST_RDA   = 10'b00_1000_0000,
    ST_RDB   = 10'b01_0000_0000,
    ST_FIN   = 10'b10_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] corner_q, corner_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    corner_d   = corner_q;
    cmd_o      = '0;
    cmd_o.corner = corner_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_kind_i == cicmd_pkg::KIND_READ) state_d = ST_RDA;
          else if (in_active_i) state_d = ST_SPLIT;
          else state_d = ST_FIN;
        end
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        corner_d    = '0;
        state_d     = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        corner_d = corner_q + 3'd1;
        state_d  = (corner_q == 3'd7) ? ST_FIN : ST_MUL1;
      end
      ST_RDA: begin
        cmd_o.rda = 1'b1;
        state_d   = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.rdb = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.fin) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      corner_q    <= corner_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unread word");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !in_ready_o)
    else $error("input taken during mesh clear");

  a_corner_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPLIT) |=> (corner_q == 3'd0 && state_q == ST_MUL1))
    else $error("corner sweep did not start at corner zero");

  a_one_mem_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr, cmd_o.mul2, cmd_o.wr, cmd_o.rda, cmd_o.rdb}))
    else $error("two memory operations in one cycle");

endmodule
`default_nettype wire

[sv/cic_mass_deposit_3d.sv]
// top level of the cloud-in-cell mass deposit block
// depends on cicmd_pkg, cicmd_ctrl and cicmd_datapath
//
//  channel   handshake               payload       direction
//  in        in_valid_i/in_ready_o   in_data_i     deposit or read word in
//  out       out_valid_o/out_ready_i out_data_o    cell and total word out
//  cfg       cfg_we_i                cfg_idx_i,    offset register write
//                                    cfg_data_i
//
// a deposit runs accept, split, then per corner the MUL1, MUL2, MUL3, WR states
// (two weight multiplies, mass multiply, read-modify-write on the one mesh port)
// and FIN to load the result; an inactive deposit goes straight to FIN, a read
// runs RDA, RDB, FIN; after reset the mesh is swept to zero with in_ready_o low
// a new word is accepted while the previous result waits in the output register
`default_nettype none
module cic_mass_deposit_3d #(
  parameter int MeshSide = cicmd_pkg::MESH_SIDE,
  parameter int PosBits  = cicmd_pkg::POS_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cicmd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cicmd_pkg::FLD_W-1:0]     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire cicmd_pkg::in_item_t             in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output cicmd_pkg::out_item_t                 out_data_o
);

  cicmd_pkg::cmd_t cmd;
  cicmd_pkg::sts_t sts;

  cicmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_kind_i   (in_data_i.kind),
    .in_active_i (in_data_i.active),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cicmd_datapath #(
    .MeshSide (MeshSide),
    .PosBits  (PosBits)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
